/* rtl/core/cmtp_pkg.sv */
// ----------------------------------------------------------------------------
// cmtp_pkg
// Types and constants shared by the color map table parser and its channels.
// ----------------------------------------------------------------------------
package cmtp_pkg;

	// status codes of a result
	localparam logic [1:0] ST_ENTRY       = 2'd0;
	localparam logic [1:0] ST_BAD_DEPTH   = 2'd1;
	localparam logic [1:0] ST_EMPTY_RANGE = 2'd2;

	// depth codes from the header
	localparam logic [1:0] DEPTH_NIBBLE  = 2'd0;
	localparam logic [1:0] DEPTH_BYTE    = 2'd1;
	localparam logic [1:0] DEPTH_WORD    = 2'd2;
	localparam logic [1:0] DEPTH_UNKNOWN = 2'd3;

	// full index range by depth when no range is given
	localparam logic [15:0] END_NIBBLE = 16'd15;
	localparam logic [15:0] END_BYTE   = 16'd255;
	localparam logic [15:0] END_WORD   = 16'd65535;

	// fixed-point color conversion coefficients, 16 fractional bits
	localparam logic signed [27:0] K_Y     = 28'sd76309;
	localparam logic signed [27:0] K_R_CR  = 28'sd104597;
	localparam logic signed [27:0] K_G_CB  = 28'sd25675;
	localparam logic signed [27:0] K_G_CR  = 28'sd53279;
	localparam logic signed [27:0] K_B_CB  = 28'sd132201;
	localparam logic signed [27:0] K_ROUND = 28'sd32768;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       table_start;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] entry_index;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic        last_entry;
	} out_item_t;

endpackage

/* rtl/core/cmtp_stream_if.sv */
// ----------------------------------------------------------------------------
// cmtp_stream_if
// Valid/ready channel carrying one payload item per request.
// ----------------------------------------------------------------------------
interface cmtp_stream_if #(
	parameter type payload_t = cmtp_pkg::in_item_t
) ();

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);

endinterface

/* rtl/core/color_map_table_parser_core.sv */
// ----------------------------------------------------------------------------
// color_map_table_parser_core
// Color lookup table stream parser with YCbCr to RGB conversion.
// ----------------------------------------------------------------------------
// Usage:
// byte_chan takes one stream byte per request; table_start marks a header.
// result_chan gives at most one result per byte: a palette entry (status 0)
// with index, RGB components, alpha and last flag, or a status report for an
// unknown depth code or an empty index range.
// A byte is registered on acceptance and parsed in the next cycle; its result
// is loaded into the result register when that register is empty or being
// taken, and it waits there until the receiver takes it.
// Throughput is one byte per cycle while result_chan does not stall, set by
// the single parse and conversion step between the input and result registers.
// While result_chan stalls with a result waiting, one more byte is taken into
// the input register, then byte_chan ready drops until the result leaves.
// Reset puts the parser idle, waiting for a header byte, with both
// registers empty; bytes without table_start are dropped while idle.
// ----------------------------------------------------------------------------
module color_map_table_parser_core (
	input  logic            clk,
	input  logic            arst_n,
	cmtp_stream_if.sink     byte_chan,
	cmtp_stream_if.source   result_chan
);

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_REGION = 2'd1;
	localparam logic [1:0] PH_RANGE  = 2'd2;
	localparam logic [1:0] PH_ENTRY  = 2'd3;

	// input register
	logic                 in_valid_s1;
	cmtp_pkg::in_item_t   in_item_s1;

	// result register
	logic                 res_valid_s2;
	cmtp_pkg::out_item_t  res_item_s2;

	// parser state
	logic [1:0]  phase_q,   phase_d;
	logic [2:0]  count_q,   count_d;
	logic        is_rgb_q,  is_rgb_d;
	logic [1:0]  depth_q,   depth_d;
	logic        region_q,  region_d;
	logic        range_q,   range_d;
	logic [15:0] cur_q,     cur_d;
	logic [15:0] fin_q,     fin_d;
	logic [7:0]  held_q [3];
	logic [7:0]  held_d [3];

	logic                 emit;
	cmtp_pkg::out_item_t  res_d;
	logic                 advance;
	logic [7:0]           b;
	logic [7:0]           conv_r, conv_g, conv_b;

	function automatic logic [7:0] clamp_scaled(input logic signed [27:0] sum);
		logic [7:0] v;
		if (sum[27])
			v = 8'd0;
		else if (|sum[26:24])
			v = 8'd255;
		else
			v = sum[23:16];
		return v;
	endfunction

	assign advance         = !res_valid_s2 || result_chan.ready;
	assign byte_chan.ready = !in_valid_s1 || advance;
	assign result_chan.valid   = res_valid_s2;
	assign result_chan.payload = res_item_s2;
	assign b = in_item_s1.data_byte;

	// ycbcr to rgb from the three held components
	always_comb begin
		logic signed [27:0] ys, cbs, crs;
		logic signed [27:0] yk, r_sum, g_sum, b_sum;
		ys    = $signed({20'd0, held_q[0]}) - 28'sd16;
		cbs   = $signed({20'd0, held_q[1]}) - 28'sd128;
		crs   = $signed({20'd0, held_q[2]}) - 28'sd128;
		yk    = ys * cmtp_pkg::K_Y;
		r_sum = yk + crs * cmtp_pkg::K_R_CR + cmtp_pkg::K_ROUND;
		g_sum = yk - cbs * cmtp_pkg::K_G_CB - crs * cmtp_pkg::K_G_CR + cmtp_pkg::K_ROUND;
		b_sum = yk + cbs * cmtp_pkg::K_B_CB + cmtp_pkg::K_ROUND;
		conv_r = clamp_scaled(r_sum);
		conv_g = clamp_scaled(g_sum);
		conv_b = clamp_scaled(b_sum);
	end

	always_comb begin
		phase_d  = phase_q;
		count_d  = count_q;
		is_rgb_d = is_rgb_q;
		depth_d  = depth_q;
		region_d = region_q;
		range_d  = range_q;
		cur_d    = cur_q;
		fin_d    = fin_q;
		held_d   = held_q;
		emit     = 1'b0;
		res_d    = '0;

		if (in_item_s1.table_start) begin
			is_rgb_d = b[7];
			depth_d  = b[6:5];
			region_d = b[4];
			range_d  = b[3];
			count_d  = 3'd0;
			if (b[6:5] == cmtp_pkg::DEPTH_UNKNOWN) begin
				phase_d      = PH_IDLE;
				emit         = 1'b1;
				res_d.status = cmtp_pkg::ST_BAD_DEPTH;
			end else begin
				if (!b[3]) begin
					cur_d = 16'd0;
					unique case (b[6:5])
						cmtp_pkg::DEPTH_NIBBLE: fin_d = cmtp_pkg::END_NIBBLE;
						cmtp_pkg::DEPTH_BYTE:   fin_d = cmtp_pkg::END_BYTE;
						default:                fin_d = cmtp_pkg::END_WORD;
					endcase
				end
				if (b[4])
					phase_d = PH_REGION;
				else
					phase_d = b[3] ? PH_RANGE : PH_ENTRY;
			end
		end else begin
			unique case (phase_q)
				PH_REGION: begin
					if (count_q >= 3'd7) begin
						count_d = 3'd0;
						phase_d = range_q ? PH_RANGE : PH_ENTRY;
					end else begin
						count_d = count_q + 3'd1;
					end
				end
				PH_RANGE: begin
					logic done;
					done = 1'b0;
					unique case (depth_q)
						cmtp_pkg::DEPTH_NIBBLE: begin
							cur_d = {12'd0, b[7:4]};
							fin_d = {12'd0, b[3:0]};
							done  = 1'b1;
						end
						cmtp_pkg::DEPTH_BYTE: begin
							if (count_q == 3'd0) begin
								cur_d = {8'd0, b};
							end else begin
								fin_d = {8'd0, b};
								done  = 1'b1;
							end
						end
						default: begin
							unique case (count_q)
								3'd0:    cur_d = {b, 8'd0};
								3'd1:    cur_d = {cur_q[15:8], b};
								3'd2:    fin_d = {b, 8'd0};
								default: begin
									fin_d = {fin_q[15:8], b};
									done  = 1'b1;
								end
							endcase
						end
					endcase
					if (!done) begin
						count_d = count_q + 3'd1;
					end else begin
						count_d = 3'd0;
						if (cur_d > fin_d) begin
							phase_d      = PH_IDLE;
							emit         = 1'b1;
							res_d.status = cmtp_pkg::ST_EMPTY_RANGE;
						end else begin
							phase_d = PH_ENTRY;
						end
					end
				end
				PH_ENTRY: begin
					if (count_q < 3'd3) begin
						held_d[count_q[1:0]] = b;
						count_d = count_q + 3'd1;
					end else begin
						count_d           = 3'd0;
						emit              = 1'b1;
						res_d.status      = cmtp_pkg::ST_ENTRY;
						res_d.entry_index = cur_q;
						res_d.red         = is_rgb_q ? held_q[0] : conv_r;
						res_d.green       = is_rgb_q ? held_q[1] : conv_g;
						res_d.blue        = is_rgb_q ? held_q[2] : conv_b;
						res_d.alpha       = b;
						res_d.last_entry  = (cur_q == fin_q);
						if (cur_q == fin_q)
							phase_d = PH_IDLE;
						else
							cur_d = cur_q + 16'd1;
					end
				end
				default: begin
					// stray bytes while idle are dropped
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (byte_chan.ready) begin
			in_valid_s1 <= byte_chan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_chan.ready && byte_chan.valid)
			in_item_s1 <= byte_chan.payload;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
			phase_q      <= PH_IDLE;
			count_q      <= 3'd0;
			is_rgb_q     <= 1'b0;
			depth_q      <= cmtp_pkg::DEPTH_NIBBLE;
			region_q     <= 1'b0;
			range_q      <= 1'b0;
			cur_q        <= 16'd0;
			fin_q        <= 16'd0;
			held_q[0]    <= 8'd0;
			held_q[1]    <= 8'd0;
			held_q[2]    <= 8'd0;
		end else if (advance) begin
			res_valid_s2 <= in_valid_s1 && emit;
			if (in_valid_s1) begin
				phase_q  <= phase_d;
				count_q  <= count_d;
				is_rgb_q <= is_rgb_d;
				depth_q  <= depth_d;
				region_q <= region_d;
				range_q  <= range_d;
				cur_q    <= cur_d;
				fin_q    <= fin_d;
				held_q   <= held_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid_s1 && emit)
			res_item_s2 <= res_d;
	end

endmodule
